// File: hdl/ges_pkg.sv
// ----------------------------------------------------------------------------
// ges_pkg
// Shared constants, controller states and the command and status bundles
// that join the gap exchange sorter controller to its datapath.
// ----------------------------------------------------------------------------
package ges_pkg;

    localparam int MAX_ITEMS_DEF  = 64;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int VALUE_W        = 32;
    localparam int SWAP_W         = 16;

    typedef enum logic [3:0] {
        S_LOAD,
        S_GAP_SET,
        S_GAP_CHK,
        S_RD_I,
        S_LD_A,
        S_CMP,
        S_WR_I,
        S_OUT_RD,
        S_OUT_LD,
        S_OUT_WAIT
    } t_ges_state;

    typedef struct packed {
        logic load;       // store the incoming word
        logic gap_init;   // gap = count / 2, i = 0
        logic gap_halve;  // gap = gap / 2, i = 0
        logic rd_i;       // read element i, j = i + gap
        logic ld_a;       // capture element i, read element j
        logic cmp;        // compare-exchange element j, advance j
        logic wr_i;       // write back element i, advance i
        logic out_rd;     // read element k for emission
        logic out_ld;     // load the output register
        logic out_next;   // advance k
        logic set_done;   // clear count, swap counter and k
    } t_ges_cmd;

    typedef struct packed {
        logic gap_zero;
        logic ig_lt_n;
        logic jn_lt_n;
        logic out_fire;
        logic out_end;
    } t_ges_status;

endpackage

// File: hdl/gap_exchange_sorter_top.sv
// ----------------------------------------------------------------------------
// gap_exchange_sorter_top
// Collects a set of signed words and returns it sorted ascending, with the
// number of exchanges the gap-halving sort needed.
// ----------------------------------------------------------------------------
// Words are taken one transfer per cycle until a transfer with i_last set;
// up to MAX_ITEMS words are kept and any further ones dropped, though a
// dropped word carrying i_last still closes the set. The block then sorts
// in place: the gap starts at half the count and halves down to one, and
// for each position i every element at i+gap, i+2*gap, ... is compared
// with element i and exchanged when element i is greater. The element
// memory has one read and one write port, so the sort runs one
// compare-exchange per cycle, plus steps that read, capture and write
// back each position and check and halve each gap, with o_stall high.
// The set then leaves one word at a time, each read, loaded into the
// output register and held until its transfer completes; o_end_of_set
// marks the final word and o_swap_count (saturating at 65535) repeats
// on every word. The next set is taken once the final transfer completes.
// ----------------------------------------------------------------------------
module gap_exchange_sorter_top
    import ges_pkg::*;
#(
    parameter int MAX_ITEMS  = MAX_ITEMS_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // input channel
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic signed [VALUE_W-1:0] i_value,
    input  logic                      i_last,
    // result channel
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic signed [VALUE_W-1:0] o_sorted_value,
    output logic                      o_end_of_set,
    output logic [SWAP_W-1:0]         o_swap_count
);

    t_ges_cmd    cmd;
    t_ges_status status;

    // sequencing of load, sort passes and emission
    ges_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_last   (i_last),
        .o_stall  (o_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // memory, compare-exchange and output register
    ges_datapath #(
        .MAX_ITEMS  (MAX_ITEMS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_value        (i_value),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_sorted_value (o_sorted_value),
        .o_end_of_set   (o_end_of_set),
        .o_swap_count   (o_swap_count)
    );

endmodule

// File: hdl/ges_ctrl.sv
// ----------------------------------------------------------------------------
// ges_ctrl
// Controller state machine: loading, gap passes, compare-exchange sweep and
// emission of the sorted set.
// ----------------------------------------------------------------------------
module ges_ctrl
    import ges_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_last,
    output logic        o_stall,
    input  t_ges_status i_status,
    output t_ges_cmd    o_cmd
);

    t_ges_state r_state;
    t_ges_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD: begin
                if (i_valid && i_last) n_state = S_GAP_SET;
            end
            S_GAP_SET: n_state = S_GAP_CHK;
            S_GAP_CHK: begin
                n_state = i_status.gap_zero ? S_OUT_RD : S_RD_I;
            end
            S_RD_I: begin
                n_state = i_status.ig_lt_n ? S_LD_A : S_GAP_CHK;
            end
            S_LD_A: n_state = S_CMP;
            S_CMP: begin
                if (!i_status.jn_lt_n) n_state = S_WR_I;
            end
            S_WR_I:   n_state = S_RD_I;
            S_OUT_RD: n_state = S_OUT_LD;
            S_OUT_LD: n_state = S_OUT_WAIT;
            S_OUT_WAIT: begin
                if (i_status.out_fire) begin
                    n_state = i_status.out_end ? S_LOAD : S_OUT_RD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        unique case (r_state)
            S_LOAD: begin
                o_stall    = 1'b0;
                o_cmd.load = i_valid;
            end
            S_GAP_SET: o_cmd.gap_init = 1'b1;
            S_GAP_CHK: ;
            S_RD_I: begin
                o_cmd.rd_i      = i_status.ig_lt_n;
                o_cmd.gap_halve = !i_status.ig_lt_n;
            end
            S_LD_A:   o_cmd.ld_a   = 1'b1;
            S_CMP:    o_cmd.cmp    = 1'b1;
            S_WR_I:   o_cmd.wr_i   = 1'b1;
            S_OUT_RD: o_cmd.out_rd = 1'b1;
            S_OUT_LD: o_cmd.out_ld = 1'b1;
            S_OUT_WAIT: begin
                o_cmd.out_next = i_status.out_fire && !i_status.out_end;
                o_cmd.set_done = i_status.out_fire && i_status.out_end;
            end
            default: ;
        endcase
    end

endmodule

// File: hdl/ges_datapath.sv
// ----------------------------------------------------------------------------
// ges_datapath
// Element memory, index counters, compare-exchange unit, swap counter and
// output register.
// ----------------------------------------------------------------------------
module ges_datapath
    import ges_pkg::*;
#(
    parameter int MAX_ITEMS  = MAX_ITEMS_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_ges_cmd                  i_cmd,
    output t_ges_status               o_status,
    input  logic signed [VALUE_W-1:0] i_value,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic signed [VALUE_W-1:0] o_sorted_value,
    output logic                      o_end_of_set,
    output logic [SWAP_W-1:0]         o_swap_count
);

    localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int SW = CW + 1;
    localparam int DW = DATA_WIDTH;

    logic signed [DW-1:0] r_mem [MAX_ITEMS];
    logic signed [DW-1:0] r_rdata;
    logic signed [DW-1:0] r_a;
    logic [CW-1:0]        r_count;
    logic [CW-1:0]        r_gap;
    logic [AW-1:0]        r_i;
    logic [AW-1:0]        r_j;
    logic [AW-1:0]        r_k;
    logic [SWAP_W-1:0]    r_swaps;
    logic                 r_out_valid;
    logic                 r_out_end;
    logic signed [VALUE_W-1:0] r_out_value;

    logic [AW-1:0]        raddr;
    logic                 we;
    logic [AW-1:0]        waddr;
    logic signed [DW-1:0] wdata;
    logic                 full;
    logic                 swap;
    logic                 out_fire;
    logic [SW-1:0]        i_plus_gap;
    logic [SW-1:0]        j_next;

    assign full       = (r_count == CW'(MAX_ITEMS));
    assign i_plus_gap = SW'(r_i) + SW'(r_gap);
    assign j_next     = SW'(r_j) + SW'(r_gap);
    assign swap       = i_cmd.cmp && (r_a > r_rdata);
    assign out_fire   = r_out_valid && !i_stall;

    assign o_status.gap_zero = (r_gap == '0);
    assign o_status.ig_lt_n  = (i_plus_gap < SW'(r_count));
    assign o_status.jn_lt_n  = (j_next < SW'(r_count));
    assign o_status.out_fire = out_fire;
    assign o_status.out_end  = r_out_end;

    // read address
    always_comb begin
        priority if (i_cmd.rd_i) begin
            raddr = r_i;
        end else if (i_cmd.ld_a) begin
            raddr = r_j;
        end else if (i_cmd.cmp) begin
            raddr = j_next[AW-1:0];
        end else begin
            raddr = r_k;
        end
    end

    // write port
    always_comb begin
        we    = 1'b0;
        waddr = r_i;
        wdata = r_a;
        priority if (i_cmd.load) begin
            we    = !full;
            waddr = r_count[AW-1:0];
            wdata = DW'(i_value);
        end else if (swap) begin
            we    = 1'b1;
            waddr = r_j;
        end else if (i_cmd.wr_i) begin
            we    = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) r_mem[waddr] <= wdata;
        r_rdata <= r_mem[raddr];
    end

    // index counters and working element
    always_ff @(posedge i_clk) begin
        if (i_cmd.gap_init) begin
            r_gap <= r_count >> 1;
            r_i   <= '0;
        end
        if (i_cmd.gap_halve) begin
            r_gap <= r_gap >> 1;
            r_i   <= '0;
        end
        if (i_cmd.rd_i) r_j <= i_plus_gap[AW-1:0];
        if (i_cmd.ld_a) r_a <= r_rdata;
        if (i_cmd.cmp)  r_j <= j_next[AW-1:0];
        if (swap)       r_a <= r_rdata;
        if (i_cmd.wr_i) r_i <= r_i + AW'(1);
        if (i_cmd.out_ld) begin
            r_out_value <= VALUE_W'(r_rdata);
            r_out_end   <= (SW'(r_k) + SW'(1)) == SW'(r_count);
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_swaps     <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load && !full) r_count <= r_count + CW'(1);
            if (swap && (r_swaps != '1)) r_swaps <= r_swaps + SWAP_W'(1);
            if (i_cmd.out_next) r_k <= r_k + AW'(1);
            if (i_cmd.out_ld) begin
                r_out_valid <= 1'b1;
            end else if (out_fire) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.set_done) begin
                r_count <= '0;
                r_swaps <= '0;
                r_k     <= '0;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_sorted_value = r_out_value;
    assign o_end_of_set   = r_out_end;
    assign o_swap_count   = r_swaps;

endmodule
